@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define TWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/twm_pkg.sv @@
// ---------------------------------------------------------------------------
// twm_pkg
// Types, codes and sizes shared by the timer wheel files.
// ---------------------------------------------------------------------------
package twm_pkg;

  localparam int NumTimers = 16;
  localparam int WheelSize = 64;   // power of two
  localparam int TickBits  = 32;

  localparam int TimerW = $clog2(NumTimers);
  localparam int WheelW = $clog2(WheelSize);

  localparam int OpW    = 3;
  localparam int IndexW = 4;
  localparam int ValueW = 32;
  localparam int KindW  = 2;

  localparam logic [OpW-1:0] OP_START     = 3'd0;
  localparam logic [OpW-1:0] OP_STOP      = 3'd1;
  localparam logic [OpW-1:0] OP_TICK      = 3'd2;
  localparam logic [OpW-1:0] OP_READ_TOUT = 3'd3;
  localparam logic [OpW-1:0] OP_READ_DATE = 3'd4;

  localparam logic [KindW-1:0] KIND_ACK   = 2'd0;
  localparam logic [KindW-1:0] KIND_FIRED = 2'd1;
  localparam logic [KindW-1:0] KIND_DONE  = 2'd2;
  localparam logic [KindW-1:0] KIND_ANSW  = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [IndexW-1:0] timer_index;
    logic [ValueW-1:0] start_delay;
    logic [ValueW-1:0] reload_interval;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IndexW-1:0] fired_index;
    logic [ValueW-1:0] answer;
    logic              last;
  } rsp_t;

  // One timer table entry.
  typedef struct packed {
    logic [TickBits-1:0] reload;
    logic [TickBits-1:0] expiry;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

@@ hdl/twm_ifs.sv @@
// ---------------------------------------------------------------------------
// twm_ifs
// Valid/ready channels for requests and result items.
// ---------------------------------------------------------------------------
interface twm_req_if;
  import twm_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface twm_rsp_if;
  import twm_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/timer_wheel_manager.sv @@
// ---------------------------------------------------------------------------
// timer_wheel_manager
// Periodic timer wheel over a table of 16 timers.
// ---------------------------------------------------------------------------
// Requests come in on req (start, stop, tick, read timeout, read date);
// result items leave on rsp through a single output register.
// Start, stop and unknown opcodes give one acknowledge in the cycle after
// the request is taken. Queries answer after a read of the timer table
// memory; the read data is registered, then the answer is pushed out.
// A tick scans the table one entry per cycle, unless a fired item stalls,
// through the memory read port: one fired item per expired timer, then
// the done item. A tick keeps the block busy until it pushes the done item.
// Only one request is worked on at a time; req.ready is high when the
// block is idle and its output register is free or being emptied.
// When rsp.ready is low the result item holds and the scan pauses on the
// entry that wants to fire.
// Reset clears the tick count and all armed bits; table entries are used
// only for armed timers, so the memory needs no clearing pass.
// ---------------------------------------------------------------------------
module timer_wheel_manager (
  input  logic       clk,
  input  logic       rst,
  twm_req_if.sink    req,
  twm_rsp_if.source  rsp
);
  import twm_pkg::*;

  state_t state, state_next;

  logic [TickBits-1:0]  tick_count;
  logic [NumTimers-1:0] armed;

  entry_t               mem [NumTimers];
  entry_t               rd_data;
  logic                 rd_en;
  logic [TimerW-1:0]    rd_addr;
  logic                 wr_en;
  logic [TimerW-1:0]    wr_addr;
  entry_t               wr_data;

  logic                 arm_set;
  logic                 arm_clr;
  logic [TimerW-1:0]    arm_idx;

  logic [TimerW:0]      scan_cnt;
  logic                 eval_vld;
  logic [TimerW-1:0]    eval_idx;

  logic [OpW-1:0]       qry_op;
  logic [IndexW-1:0]    qry_index;
  logic                 qry_ok;

  logic                 out_valid;
  rsp_t                 out_item;
  logic                 push;
  rsp_t                 push_item;

  logic                 accept;
  logic                 out_free;
  logic                 idx_ok;
  logic                 fire;
  logic                 stall;
  logic                 scan_end;
  logic [TickBits-1:0]  qry_value;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign idx_ok    = {1'b0, req.payload.timer_index} < (IndexW + 1)'(NumTimers);

  assign fire = eval_vld && armed[eval_idx]
             && (rd_data.expiry[WheelW-1:0] == tick_count[WheelW-1:0])
             && (rd_data.expiry <= tick_count);
  assign stall    = fire && !out_free;
  assign scan_end = (scan_cnt == (TimerW + 1)'(NumTimers));

  assign qry_value = (qry_op == OP_READ_TOUT) ? (rd_data.expiry - tick_count)
                                              : rd_data.expiry;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.payload.opcode == OP_TICK) begin
            state_next = ST_SCAN;
          end else if (req.payload.opcode == OP_READ_TOUT ||
                       req.payload.opcode == OP_READ_DATE) begin
            state_next = ST_QUERY;
          end
        end
      end
      ST_QUERY: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_end && !stall) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = scan_cnt[TimerW-1:0];
    wr_en     = 1'b0;
    wr_addr   = eval_idx;
    wr_data   = '{reload: rd_data.reload,
                  expiry: tick_count + rd_data.reload};
    arm_set   = 1'b0;
    arm_clr   = 1'b0;
    arm_idx   = eval_idx;
    push      = 1'b0;
    push_item = '{kind: KIND_ACK, fired_index: req.payload.timer_index,
                  answer: '0, last: 1'b1};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.payload.opcode)
            OP_START: begin
              push    = 1'b1;
              wr_en   = idx_ok;
              wr_addr = req.payload.timer_index[TimerW-1:0];
              arm_idx = req.payload.timer_index[TimerW-1:0];
              if (req.payload.start_delay != '0) begin
                wr_data = '{reload: TickBits'(req.payload.reload_interval),
                            expiry: tick_count
                                    + TickBits'(req.payload.start_delay)};
                arm_set = idx_ok;
              end else begin
                wr_data = '0;
                arm_clr = idx_ok;
              end
            end
            OP_STOP: begin
              push    = 1'b1;
              arm_idx = req.payload.timer_index[TimerW-1:0];
              arm_clr = idx_ok;
            end
            OP_TICK: ;
            OP_READ_TOUT, OP_READ_DATE: begin
              rd_en   = 1'b1;
              rd_addr = req.payload.timer_index[TimerW-1:0];
            end
            default: push = 1'b1;
          endcase
        end
      end
      ST_QUERY: begin
        push      = 1'b1;
        push_item = '{kind: KIND_ANSW, fired_index: qry_index,
                      answer: (qry_ok && armed[qry_index[TimerW-1:0]])
                              ? ValueW'(qry_value) : '0,
                      last: 1'b1};
      end
      ST_SCAN: begin
        if (!stall) begin
          rd_en = !scan_end;
          if (fire) begin
            push      = 1'b1;
            push_item = '{kind: KIND_FIRED, fired_index: IndexW'(eval_idx),
                          answer: ValueW'(tick_count), last: 1'b0};
            // periodic timers move to their next date, one-shots disarm
            wr_en     = (rd_data.reload != '0);
            arm_clr   = (rd_data.reload == '0);
          end
        end
      end
      ST_DONE: begin
        push      = out_free;
        push_item = '{kind: KIND_DONE, fired_index: '0,
                      answer: ValueW'(tick_count), last: 1'b1};
      end
      default: ;
    endcase
  end

  // Timer table
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      armed      <= '0;
      scan_cnt   <= '0;
      eval_vld   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (arm_set) armed[arm_idx] <= 1'b1;
      if (arm_clr) armed[arm_idx] <= 1'b0;
      if (accept && req.payload.opcode == OP_TICK) begin
        tick_count <= tick_count + 1'b1;
        scan_cnt   <= '0;
        eval_vld   <= 1'b0;
      end else if (state == ST_SCAN && !stall) begin
        if (!scan_end) begin
          scan_cnt <= scan_cnt + 1'b1;
          eval_vld <= 1'b1;
        end else begin
          eval_vld <= 1'b0;
        end
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_item <= push_item;
    if (state == ST_SCAN && !stall && !scan_end) eval_idx <= scan_cnt[TimerW-1:0];
    if (accept) begin
      qry_op    <= req.payload.opcode;
      qry_index <= req.payload.timer_index;
      qry_ok    <= idx_ok;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

endmodule

@@ hdl/twm_checker.sv @@
// ---------------------------------------------------------------------------
// twm_checker
// Port-level checks on the timer wheel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module twm_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input twm_pkg::req_t req_payload,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input twm_pkg::rsp_t rsp_payload
);
  import twm_pkg::*;

  logic req_take;
  assign req_take = req_valid && req_ready;

  `TWM_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !rsp_valid, "result after reset")
  `TWM_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled result changed")
  `TWM_ASSERT(a_start_ack, clk, rst, req_take && req_payload.opcode == OP_START |=> rsp_valid && rsp_payload.kind == KIND_ACK && rsp_payload.last, "start not acknowledged")
  `TWM_ASSERT(a_tick_busy, clk, rst, req_take && req_payload.opcode == OP_TICK |=> !req_ready, "request taken during tick scan")
  `TWM_ASSERT(a_scan_blocks, clk, rst, rsp_valid && !rsp_payload.last |-> !req_ready, "request taken before done item")

endmodule

bind timer_wheel_manager twm_checker u_twm_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_payload (req.payload),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic timer wheel.
// Requests go in through a bursty driver fed from a command queue. Every
// accepted request runs through a local model of the timer table, which
// queues the result items it should produce. A monitor checks each result
// against the oldest queued item while the receiver stalls on a pattern.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import twm_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int SettleCycles = 40;

  // opcodes the block treats as unknown
  localparam logic [OpW-1:0] OP_SPARE_LO = OP_READ_DATE + 1'b1;
  localparam logic [OpW-1:0] OP_SPARE_HI = '1;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SLOW,
    RX_CHOKE
  } rx_mode_e;

  logic clk;
  logic rst;

  twm_req_if req_ch ();
  twm_rsp_if rsp_ch ();

  timer_wheel_manager u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // model of the timer table
  logic [TickBits-1:0] wheel_now;
  logic [TickBits-1:0] due_date [NumTimers];
  logic [TickBits-1:0] period [NumTimers];
  bit                  live [NumTimers];

  req_t cmd_queue [$];
  rsp_t awaited [$];

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  rx_mode_e stall_mode = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic req_t cmd(logic [OpW-1:0] op, logic [IndexW-1:0] idx,
                               logic [ValueW-1:0] delay, logic [ValueW-1:0] reload);
    req_t c;
    c.opcode = op;
    c.timer_index = idx;
    c.start_delay = delay;
    c.reload_interval = reload;
    return c;
  endfunction

  function automatic rsp_t make_item(logic [KindW-1:0] k, logic [IndexW-1:0] idx,
                                     logic [ValueW-1:0] a, logic l);
    rsp_t r;
    r.kind = k;
    r.fired_index = idx;
    r.answer = a;
    r.last = l;
    return r;
  endfunction

  // Mostly ticks and starts with short delays so timers actually fire and
  // reload; the rest is stops, queries, odd opcodes and full-range values.
  function automatic req_t random_command();
    int unsigned pick;
    logic [ValueW-1:0] delay;
    logic [ValueW-1:0] reload;
    logic [IndexW-1:0] idx;
    pick = $urandom_range(99);
    idx = IndexW'($urandom_range(NumTimers - 1));
    if ($urandom_range(99) < 8) delay = '0;
    else if ($urandom_range(99) < 75) delay = $urandom_range(1, 90);
    else delay = $urandom;
    if ($urandom_range(9) < 3) reload = '0;
    else if ($urandom_range(9) < 7) reload = $urandom_range(1, 70);
    else reload = $urandom;
    if (pick < 42) return cmd(OP_TICK, idx, $urandom, $urandom);
    if (pick < 66) return cmd(OP_START, idx, delay, reload);
    if (pick < 74) return cmd(OP_STOP, idx, $urandom, $urandom);
    if (pick < 83) return cmd(OP_READ_TOUT, idx, $urandom, $urandom);
    if (pick < 92) return cmd(OP_READ_DATE, idx, $urandom, $urandom);
    if (pick < 96) return cmd(OpW'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), idx,
                              $urandom, $urandom);
    return cmd(OP_START, idx, $urandom, $urandom);
  endfunction

  task automatic apply_command(input req_t c);
    logic [ValueW-1:0] ans;
    bit in_table;
    ans = '0;
    in_table = (int'(c.timer_index) < NumTimers);
    case (c.opcode)
      OP_START: begin
        if (in_table) begin
          if (c.start_delay != '0) begin
            due_date[c.timer_index] = wheel_now + c.start_delay;
            period[c.timer_index] = c.reload_interval;
            live[c.timer_index] = 1'b1;
          end else begin
            due_date[c.timer_index] = '0;
            period[c.timer_index] = '0;
            live[c.timer_index] = 1'b0;
          end
        end
        awaited.push_back(make_item(KIND_ACK, c.timer_index, '0, 1'b1));
      end
      OP_STOP: begin
        if (in_table) live[c.timer_index] = 1'b0;
        awaited.push_back(make_item(KIND_ACK, c.timer_index, '0, 1'b1));
      end
      OP_TICK: begin
        wheel_now = wheel_now + 1'b1;
        for (int i = 0; i < NumTimers; i++) begin
          // slot match plus an unsigned date compare; wrapped dates fire early
          if (live[i] && due_date[i][WheelW-1:0] == wheel_now[WheelW-1:0] &&
              due_date[i] <= wheel_now) begin
            awaited.push_back(make_item(KIND_FIRED, IndexW'(i), wheel_now, 1'b0));
            if (period[i] != '0) due_date[i] = wheel_now + period[i];
            else live[i] = 1'b0;
          end
        end
        awaited.push_back(make_item(KIND_DONE, '0, wheel_now, 1'b1));
      end
      OP_READ_TOUT: begin
        if (in_table && live[c.timer_index]) ans = due_date[c.timer_index] - wheel_now;
        awaited.push_back(make_item(KIND_ANSW, c.timer_index, ans, 1'b1));
      end
      OP_READ_DATE: begin
        if (in_table && live[c.timer_index]) ans = due_date[c.timer_index];
        awaited.push_back(make_item(KIND_ANSW, c.timer_index, ans, 1'b1));
      end
      default: begin
        awaited.push_back(make_item(KIND_ACK, c.timer_index, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [ValueW-1:0] want, logic [ValueW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || req_ch.valid || awaited.size() != 0);
  endtask

  // request driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_command(req_ch.payload);
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left == 0 && cmd_queue.size() > 0) begin
          req_ch.valid <= 1'b1;
          req_ch.payload <= cmd_queue.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
            gap_left = ($urandom_range(9) == 0) ? $urandom_range(10, 25)
                                                : $urandom_range(0, 4);
          end
        end else begin
          req_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver: switches at random between stall patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_e'($urandom_range(3));
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_OPEN: rsp_ch.ready <= 1'b1;
      RX_COIN: rsp_ch.ready <= ($urandom_range(1) == 0);
      RX_SLOW: rsp_ch.ready <= (stall_left % 4 == 0);
      default: rsp_ch.ready <= ($urandom_range(9) < 3);
    endcase
  end

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: kind %0d index %0d answer %0h",
               rsp_ch.payload.kind, rsp_ch.payload.fired_index, rsp_ch.payload.answer);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        check_field("kind", ValueW'(want.kind), ValueW'(rsp_ch.payload.kind));
        check_field("fired_index", ValueW'(want.fired_index),
                    ValueW'(rsp_ch.payload.fired_index));
        check_field("answer", want.answer, rsp_ch.payload.answer);
        check_field("last", ValueW'(want.last), ValueW'(rsp_ch.payload.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    wheel_now = '0;
    for (int i = 0; i < NumTimers; i++) begin
      due_date[i] = '0;
      period[i] = '0;
      live[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle table: queries answer zero, stop of a disarmed timer, odd opcode
    cmd_queue.push_back(cmd(OP_READ_TOUT, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_queue.push_back(cmd(OP_SPARE_HI, 4'd10, 32'd0, 32'd0));
    cmd_queue.push_back(cmd(OP_STOP, 4'd5, 32'd0, 32'd0));
    // every timer due on the next tick: one-shot, reloads, a reload near the top of the range
    for (int i = 0; i < NumTimers; i++)
      cmd_queue.push_back(cmd(OP_START, IndexW'(i), 32'd1,
                              (i == 0) ? 32'd0 :
                              (i == NumTimers - 1) ? 32'hFFFF_FFFE : 32'(i * 3)));
    cmd_queue.push_back(cmd(OP_TICK, 4'd0, 32'd0, 32'd0));
    // re-arm an armed timer with a date that wraps below now: overdue timeout
    cmd_queue.push_back(cmd(OP_START, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_queue.push_back(cmd(OP_READ_TOUT, 4'd2, 32'd0, 32'd0));
    cmd_queue.push_back(cmd(OP_READ_DATE, 4'd15, 32'd0, 32'd0));
    cmd_queue.push_back(cmd(OP_START, 4'd4, 32'd0, 32'h1234));
    cmd_queue.push_back(cmd(OP_STOP, 4'd5, 32'd0, 32'd0));
    wait_quiet();

    // random traffic in two halves; the sender holds off between them
    repeat (2) begin
      repeat (180) cmd_queue.push_back(random_command());
      wait_quiet();
    end

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
